// File: src/qmpc_pkg.sv
// Shared types and constants for the quad marker pose check pipeline.
// No dependencies; imported by qmpc_step and quad_marker_pose_check_core.
`default_nettype none
package qmpc_pkg;

    localparam int SQRT_STEPS   = 17;
    localparam int CORDIC_STEPS = 16;
    localparam int FULL_TURN    = 23040;

    // 90 degrees in 1/4096 degree units.
    localparam logic signed [21:0] QUARTER_Z = 22'sd368640;

    localparam logic signed [21:0] ATAN_TAB [CORDIC_STEPS] = '{
        22'sd184320, 22'sd108810, 22'sd57492, 22'sd29251,
        22'sd14649,  22'sd7331,   22'sd3667,  22'sd1833,
        22'sd917,    22'sd458,    22'sd229,   22'sd115,
        22'sd57,     22'sd29,     22'sd14,    22'sd7
    };

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_SHORT = 2'd1;
    localparam logic [1:0] ST_SKEW  = 2'd2;

    localparam logic [1:0] REG_HEADING  = 2'd0;
    localparam logic [1:0] REG_MIN_SIDE = 2'd1;
    localparam logic [1:0] REG_SKEW     = 2'd2;

    typedef struct packed {
        logic [35:0] rem;
        logic [16:0] root;
    } sq_t;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [21:0] z;
        logic               zero;
    } cd_t;

    typedef struct packed {
        logic signed [15:0] cx;
        logic signed [15:0] cy;
    } ctr_t;

endpackage
`default_nettype wire

// File: src/qmpc_step.sv
// One pipeline stage: one root digit for each of the four sides and, when STEP is
// below CORDIC_STEPS, one CORDIC vectoring iteration. Depends on qmpc_pkg.
`default_nettype none
module qmpc_step
    import qmpc_pkg::*;
#(
    parameter int STEP = 0
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        en,
    input  wire logic        vld_in,
    input  wire sq_t  [3:0]  sq_in,
    input  wire cd_t         cd_in,
    input  wire ctr_t        ctr_in,
    output logic             vld_out,
    output sq_t   [3:0]      sq_out,
    output cd_t              cd_out,
    output ctr_t             ctr_out
);

    localparam int BIT = SQRT_STEPS - 1 - STEP;

    logic        vld_reg;
    sq_t  [3:0]  sq_reg;
    sq_t  [3:0]  sq_next;
    cd_t         cd_reg;
    cd_t         cd_next;
    ctr_t        ctr_reg;

    always_comb
    begin
        logic [35:0] sub;
        for (int k = 0; k < 4; k++)
        begin
            sub = ({18'd0, sq_in[k].root, 1'b0} | (36'd1 << BIT)) << BIT;
            sq_next[k] = sq_in[k];
            if (sq_in[k].rem >= sub)
            begin
                sq_next[k].rem  = sq_in[k].rem - sub;
                sq_next[k].root = sq_in[k].root | (17'd1 << BIT);
            end
        end
    end

    generate
        if (STEP < CORDIC_STEPS)
        begin : g_cordic
            always_comb
            begin
                logic signed [31:0] xi;
                logic signed [31:0] yi;
                logic signed [31:0] xs;
                logic signed [31:0] ys;
                xi = cd_in.x;
                yi = cd_in.y;
                xs = xi >>> STEP;
                ys = yi >>> STEP;
                cd_next = cd_in;
                if (yi > 32'sd0)
                begin
                    cd_next.x = xi + ys;
                    cd_next.y = yi - xs;
                    cd_next.z = cd_in.z + ATAN_TAB[STEP];
                end
                else
                begin
                    cd_next.x = xi - ys;
                    cd_next.y = yi + xs;
                    cd_next.z = cd_in.z - ATAN_TAB[STEP];
                end
            end
        end
        else
        begin : g_pass
            assign cd_next = cd_in;
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg <= vld_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_reg  <= sq_next;
            cd_reg  <= cd_next;
            ctr_reg <= ctr_in;
        end
    end

    assign vld_out = vld_reg;
    assign sq_out  = sq_reg;
    assign cd_out  = cd_reg;
    assign ctr_out = ctr_reg;

endmodule
`default_nettype wire

// File: src/quad_marker_pose_check_core.sv
// Top level of the quad marker pose check: side lengths, shape test, yaw,
// mean side and centre. Depends on qmpc_pkg and qmpc_step.
`default_nettype none
// Channel   Dir  Handshake                Payload
// s_axis    in   s_tvalid / s_tready      s_tdata[127:0]: eight corner coordinates
// m_axis    out  m_tvalid / m_tready      m_tdata[71:0]: status, yaw, mean side, centre
// config    in   wr_en                    wr_index[1:0], wr_data[16:0]
//
// An item passes from the input register P0 through P1 to P3, the root digit stages and R1 to R3
// into the output register; one item is accepted every cycle unless the output register stalls.
// The depth is set by the 17 root digits of the side lengths, one per stage, with
// the 16 CORDIC iterations running alongside.
// All stages advance together whenever the output register is empty or being
// taken, so a stall freezes the whole pipeline and nothing is lost or repeated.
// Reset clears the valid bits and loads the configuration registers with their reset values.
module quad_marker_pose_check_core
    import qmpc_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // Fields from bit 0 up: top_left_x, top_left_y, top_right_x, top_right_y,
    // bottom_right_x, bottom_right_y, bottom_left_x, bottom_left_y (16 bits each).
    input  wire logic [127:0] s_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // Fields from bit 0 up: status[1:0], yaw[16:2], mean_side[33:17],
    // centre_x[49:34], centre_y[65:50], zero fill [71:66].
    output logic [71:0]       m_tdata,
    input  wire logic         wr_en,
    input  wire logic [1:0]   wr_index,
    input  wire logic [16:0]  wr_data
);

    // Configuration registers.
    logic signed [15:0] heading_offset_reg;
    logic [15:0]        min_side_reg;
    logic [16:0]        skew_limit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            heading_offset_reg <= 16'sd0;
            min_side_reg       <= 16'd0;
            skew_limit_reg     <= 17'd65536;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_HEADING:  heading_offset_reg <= wr_data[15:0];
                REG_MIN_SIDE: min_side_reg       <= wr_data[15:0];
                REG_SKEW:     skew_limit_reg     <= wr_data;
                default:      ;
            endcase
        end
    end

    // The whole pipeline moves as one when the output slot is free.
    logic en;
    logic out_vld_reg;
    assign en       = !out_vld_reg || m_tready;
    assign s_tready = en;

    // Stage P0: input register.
    logic               p0_vld_reg;
    logic signed [15:0] p0_c_reg [8];

    // Stage P1: side differences, up vector and centre.
    logic               p1_vld_reg;
    logic signed [16:0] p1_dx_reg [4];
    logic signed [16:0] p1_dy_reg [4];
    logic signed [16:0] p1_upx_reg;
    logic signed [16:0] p1_upy_reg;
    ctr_t               p1_ctr_reg;

    // Stage P2: squares and CORDIC pre-rotation.
    logic               p2_vld_reg;
    logic [31:0]        p2_sqx_reg [4];
    logic [31:0]        p2_sqy_reg [4];
    cd_t                p2_cd_reg;
    ctr_t               p2_ctr_reg;

    // Stage P3: sums of squares feed the root stages.
    logic               p3_vld_reg;
    sq_t  [3:0]         p3_sq_reg;
    cd_t                p3_cd_reg;
    ctr_t               p3_ctr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p0_vld_reg <= 1'b0;
            p1_vld_reg <= 1'b0;
            p2_vld_reg <= 1'b0;
            p3_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            p0_vld_reg <= s_tvalid;
            p1_vld_reg <= p0_vld_reg;
            p2_vld_reg <= p1_vld_reg;
            p3_vld_reg <= p2_vld_reg;
        end
    end

    logic signed [16:0] p1_dx_next [4];
    logic signed [16:0] p1_dy_next [4];
    logic signed [17:0] sum_x;
    logic signed [17:0] sum_y;

    always_comb
    begin
        // Sides run TL-TR, TR-BR, BR-BL and BL-TL; corner k is x at 2k, y at 2k+1.
        for (int k = 0; k < 4; k++)
        begin
            p1_dx_next[k] = 17'(p0_c_reg[2 * k]) - 17'(p0_c_reg[(2 * k + 2) % 8]);
            p1_dy_next[k] = 17'(p0_c_reg[2 * k + 1]) - 17'(p0_c_reg[(2 * k + 3) % 8]);
        end
        sum_x = 18'(p0_c_reg[0]) + 18'(p0_c_reg[2]) + 18'(p0_c_reg[4])
              + 18'(p0_c_reg[6]) + 18'sd2;
        sum_y = 18'(p0_c_reg[1]) + 18'(p0_c_reg[3]) + 18'(p0_c_reg[5])
              + 18'(p0_c_reg[7]) + 18'sd2;
    end

    // Pre-rotation brings the vector into the right half plane.
    cd_t p2_cd_next;
    always_comb
    begin
        logic signed [31:0] xa;
        logic signed [31:0] yb;
        xa = 32'(p1_upy_reg) <<< 12;
        yb = 32'(p1_upx_reg) <<< 12;
        p2_cd_next.x    = xa;
        p2_cd_next.y    = yb;
        p2_cd_next.z    = 22'sd0;
        p2_cd_next.zero = (p1_upx_reg == 17'sd0) && (p1_upy_reg == 17'sd0);
        if (xa < 32'sd0)
        begin
            if (yb >= 32'sd0)
            begin
                p2_cd_next.x = yb;
                p2_cd_next.y = -xa;
                p2_cd_next.z = QUARTER_Z;
            end
            else
            begin
                p2_cd_next.x = -yb;
                p2_cd_next.y = xa;
                p2_cd_next.z = -QUARTER_Z;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            logic signed [33:0] px;
            logic signed [33:0] py;
            for (int k = 0; k < 8; k++)
            begin
                p0_c_reg[k] <= s_tdata[16 * k +: 16];
            end
            for (int k = 0; k < 4; k++)
            begin
                p1_dx_reg[k] <= p1_dx_next[k];
                p1_dy_reg[k] <= p1_dy_next[k];
                px = p1_dx_reg[k] * p1_dx_reg[k];
                py = p1_dy_reg[k] * p1_dy_reg[k];
                p2_sqx_reg[k] <= px[31:0];
                p2_sqy_reg[k] <= py[31:0];
                p3_sq_reg[k].rem  <= 36'(p2_sqx_reg[k]) + 36'(p2_sqy_reg[k]);
                p3_sq_reg[k].root <= 17'd0;
            end
            p1_upx_reg    <= 17'(p0_c_reg[0]) - 17'(p0_c_reg[6]);
            p1_upy_reg    <= 17'(p0_c_reg[7]) - 17'(p0_c_reg[1]);
            p1_ctr_reg.cx <= sum_x[17:2];
            p1_ctr_reg.cy <= sum_y[17:2];
            p2_cd_reg     <= p2_cd_next;
            p2_ctr_reg    <= p1_ctr_reg;
            p3_cd_reg     <= p2_cd_reg;
            p3_ctr_reg    <= p2_ctr_reg;
        end
    end

    // Root digit stages, CORDIC iterations in the first sixteen.
    logic        st_vld [SQRT_STEPS + 1];
    sq_t  [3:0]  st_sq  [SQRT_STEPS + 1];
    cd_t         st_cd  [SQRT_STEPS + 1];
    ctr_t        st_ctr [SQRT_STEPS + 1];

    assign st_vld[0] = p3_vld_reg;
    assign st_sq[0]  = p3_sq_reg;
    assign st_cd[0]  = p3_cd_reg;
    assign st_ctr[0] = p3_ctr_reg;

    generate
        for (genvar g = 0; g < SQRT_STEPS; g++)
        begin : g_step
            qmpc_step #(.STEP(g)) u_step (
                .clk     (clk),
                .rst_n   (rst_n),
                .en      (en),
                .vld_in  (st_vld[g]),
                .sq_in   (st_sq[g]),
                .cd_in   (st_cd[g]),
                .ctr_in  (st_ctr[g]),
                .vld_out (st_vld[g + 1]),
                .sq_out  (st_sq[g + 1]),
                .cd_out  (st_cd[g + 1]),
                .ctr_out (st_ctr[g + 1])
            );
        end
    endgenerate

    // Stage R1: round the roots to nearest and turn the angle into 1/64 degree.
    logic               r1_vld_reg;
    logic [16:0]        r1_side_reg [4];
    logic [16:0]        r1_u_reg;
    ctr_t               r1_ctr_reg;

    // Stage R2: min, max and sum of sides; yaw wrap.
    logic               r2_vld_reg;
    logic [16:0]        r2_min_reg;
    logic [16:0]        r2_max_reg;
    logic [16:0]        r2_mean_reg;
    logic [14:0]        r2_yaw_reg;
    ctr_t               r2_ctr_reg;

    // Stage R3: skew products.
    logic               r3_vld_reg;
    logic               r3_short_reg;
    logic [33:0]        r3_lhs_reg;
    logic [33:0]        r3_rhs_reg;
    logic [16:0]        r3_mean_reg;
    logic [14:0]        r3_yaw_reg;
    ctr_t               r3_ctr_reg;

    // Output register.
    logic [1:0]         out_status_reg;
    logic [14:0]        out_yaw_reg;
    logic [16:0]        out_mean_reg;
    ctr_t               out_ctr_reg;

    logic [16:0] r1_u_next;
    always_comb
    begin
        logic signed [21:0] phi;
        logic signed [23:0] t;
        logic signed [17:0] v;
        logic signed [17:0] w;
        cd_t                c;
        c   = st_cd[SQRT_STEPS];
        phi = c.zero ? 22'sd0 : c.z;
        t   = 24'sd0 - 24'(phi) - (24'(heading_offset_reg) <<< 6) + 24'sd32;
        v   = t[23:6];
        // Offset by two full turns so the value is positive before the wrap.
        w   = v + 18'sd46080;
        r1_u_next = w[16:0];
    end

    logic [16:0] r2_min_next;
    logic [16:0] r2_max_next;
    logic [18:0] r2_sum_next;
    logic [16:0] r2_yaw_next;
    always_comb
    begin
        r2_min_next = r1_side_reg[0];
        r2_max_next = r1_side_reg[0];
        r2_sum_next = 19'd2;
        for (int k = 0; k < 4; k++)
        begin
            if (r1_side_reg[k] < r2_min_next)
            begin
                r2_min_next = r1_side_reg[k];
            end
            if (r1_side_reg[k] > r2_max_next)
            begin
                r2_max_next = r1_side_reg[k];
            end
            r2_sum_next = r2_sum_next + 19'(r1_side_reg[k]);
        end
        if (r1_u_reg >= 17'(3 * FULL_TURN))
        begin
            r2_yaw_next = r1_u_reg - 17'(3 * FULL_TURN);
        end
        else if (r1_u_reg >= 17'(2 * FULL_TURN))
        begin
            r2_yaw_next = r1_u_reg - 17'(2 * FULL_TURN);
        end
        else if (r1_u_reg >= 17'(FULL_TURN))
        begin
            r2_yaw_next = r1_u_reg - 17'(FULL_TURN);
        end
        else
        begin
            r2_yaw_next = r1_u_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r1_vld_reg  <= 1'b0;
            r2_vld_reg  <= 1'b0;
            r3_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            r1_vld_reg  <= st_vld[SQRT_STEPS];
            r2_vld_reg  <= r1_vld_reg;
            r3_vld_reg  <= r2_vld_reg;
            out_vld_reg <= r3_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 4; k++)
            begin
                r1_side_reg[k] <= st_sq[SQRT_STEPS][k].root
                    + 17'(st_sq[SQRT_STEPS][k].rem > 36'(st_sq[SQRT_STEPS][k].root));
            end
            r1_u_reg    <= r1_u_next;
            r1_ctr_reg  <= st_ctr[SQRT_STEPS];

            r2_min_reg  <= r2_min_next;
            r2_max_reg  <= r2_max_next;
            r2_mean_reg <= r2_sum_next[18:2];
            r2_yaw_reg  <= r2_yaw_next[14:0];
            r2_ctr_reg  <= r1_ctr_reg;

            r3_short_reg <= r2_min_reg < 17'(min_side_reg);
            r3_lhs_reg   <= {1'b0, r2_max_reg - r2_min_reg, 16'd0};
            r3_rhs_reg   <= skew_limit_reg * r2_max_reg;
            r3_mean_reg  <= r2_mean_reg;
            r3_yaw_reg   <= r2_yaw_reg;
            r3_ctr_reg   <= r2_ctr_reg;

            if (r3_short_reg)
            begin
                out_status_reg <= ST_SHORT;
                out_yaw_reg    <= 15'd0;
            end
            else if (r3_lhs_reg > r3_rhs_reg)
            begin
                out_status_reg <= ST_SKEW;
                out_yaw_reg    <= 15'd0;
            end
            else
            begin
                out_status_reg <= ST_OK;
                out_yaw_reg    <= r3_yaw_reg;
            end
            out_mean_reg <= r3_mean_reg;
            out_ctr_reg  <= r3_ctr_reg;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {6'd0, out_ctr_reg.cy, out_ctr_reg.cx, out_mean_reg,
                       out_yaw_reg, out_status_reg};

    // A delivered yaw always lies inside one full turn.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[16:2] < 15'(FULL_TURN)))
        else $error("yaw outside one full turn");

    // A rejected marker carries no yaw.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tdata[1:0] != ST_OK)) |-> (m_tdata[16:2] == 15'd0))
        else $error("rejected marker with nonzero yaw");

    // The status code never takes the unused value.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[1:0] == ST_OK || m_tdata[1:0] == ST_SHORT
                      || m_tdata[1:0] == ST_SKEW))
        else $error("bad status code");

    // A stall freezes the pipeline: the last stage before the output register keeps its valid bit.
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |=> $stable(r3_vld_reg))
        else $error("pipeline moved during a stall");

endmodule
`default_nettype wire
